/* hw/rtl/ntc_pkg.sv */
// ----------------------------------------------------------------------------
// NTC conversion package
// Breakpoint ROM, field widths, status codes and the divider tag type shared
// by the temperature converter and its pipelined divider.
// ----------------------------------------------------------------------------
package ntc_pkg;

  localparam int ROM_SIZE = 43;
  localparam int ADC_W    = 12;
  localparam int TEMP_W   = 12;
  localparam int STAT_W   = 2;
  localparam int IDX_W    = $clog2(ROM_SIZE);

  // Widest gap between neighboring ADC breakpoints is 142, widest temperature
  // step is 50, so the quotient always stays below 64.
  localparam int SPAN_W = 8;
  localparam int DY_W   = 6;
  localparam int NUM_W  = SPAN_W + DY_W;
  localparam int Q_W    = DY_W;

  localparam logic [STAT_W-1:0] ST_INTERP = 2'd0;
  localparam logic [STAT_W-1:0] ST_COLD   = 2'd1;
  localparam logic [STAT_W-1:0] ST_HOT    = 2'd2;

  localparam logic [ADC_W-1:0] BP_ADC [ROM_SIZE] = '{
    12'd3994, 12'd3967, 12'd3935, 12'd3896, 12'd3851, 12'd3797, 12'd3735,
    12'd3665, 12'd3585, 12'd3496, 12'd3397, 12'd3290, 12'd3174, 12'd3050,
    12'd2920, 12'd2785, 12'd2646, 12'd2505, 12'd2363, 12'd2222, 12'd2083,
    12'd1947, 12'd1815, 12'd1688, 12'd1568, 12'd1453, 12'd1345, 12'd1244,
    12'd1149, 12'd1061, 12'd980,  12'd904,  12'd835,  12'd770,  12'd711,
    12'd657,  12'd607,  12'd562,  12'd520,  12'd482,  12'd446,  12'd414,
    12'd385
  };

  localparam logic [TEMP_W-1:0] BP_TEMP [ROM_SIZE] = '{
    12'd100,  12'd150,  12'd200,  12'd250,  12'd300,  12'd350,  12'd400,
    12'd450,  12'd500,  12'd550,  12'd600,  12'd650,  12'd700,  12'd750,
    12'd800,  12'd850,  12'd900,  12'd950,  12'd1000, 12'd1050, 12'd1100,
    12'd1150, 12'd1200, 12'd1250, 12'd1300, 12'd1350, 12'd1400, 12'd1450,
    12'd1500, 12'd1550, 12'd1600, 12'd1650, 12'd1700, 12'd1750, 12'd1800,
    12'd1850, 12'd1900, 12'd1950, 12'd2000, 12'd2050, 12'd2100, 12'd2150,
    12'd2200
  };

  typedef struct packed {
    logic [TEMP_W-1:0] base;
    logic [STAT_W-1:0] status;
  } div_tag_t;

  function automatic logic [ADC_W-1:0] adc_at(input logic [IDX_W-1:0] i);
    if (int'(i) < ROM_SIZE) return BP_ADC[i];
    return '0;
  endfunction

  function automatic logic [TEMP_W-1:0] temp_at(input logic [IDX_W-1:0] i);
    if (int'(i) < ROM_SIZE) return BP_TEMP[i];
    return '0;
  endfunction

endpackage

/* hw/rtl/ntc_div.sv */
// ----------------------------------------------------------------------------
// NTC pipelined divider
// Restoring divider, one quotient bit per register stage; a tag rides along.
// ----------------------------------------------------------------------------
module ntc_div import ntc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  num,
  input  logic [SPAN_W-1:0] span,
  input  div_tag_t          in_tag,
  output logic              out_valid,
  output logic [Q_W-1:0]    quot,
  output div_tag_t          out_tag
);

  logic              vld [Q_W+1];
  logic [NUM_W-1:0]  rem [Q_W+1];
  logic [SPAN_W-1:0] dvs [Q_W+1];
  logic [Q_W-1:0]    qb  [Q_W+1];
  div_tag_t          tag [Q_W+1];

  assign vld[0] = in_valid;
  assign rem[0] = num;
  assign dvs[0] = span;
  assign qb[0]  = '0;
  assign tag[0] = in_tag;

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    localparam int SH = Q_W - 1 - k;
    logic [NUM_W-1:0] trial;
    logic             take;

    always_comb begin
      trial = {{(NUM_W-SPAN_W){1'b0}}, dvs[k]} << SH;
      take  = rem[k] >= trial;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
      rem[k+1] <= take ? rem[k] - trial : rem[k];
      qb[k+1]  <= qb[k] | ({{(Q_W-1){1'b0}}, take} << SH);
      dvs[k+1] <= dvs[k];
      tag[k+1] <= tag[k];
    end
  end

  assign out_valid = vld[Q_W];
  assign quot      = qb[Q_W];
  assign out_tag   = tag[Q_W];

endmodule

/* hw/rtl/ntc_adc_to_temperature_unit.sv */
// ----------------------------------------------------------------------------
// NTC ADC to temperature unit
// Converts a 12-bit thermistor ADC sample to tenths of a degree Celsius by
// breakpoint search and linear interpolation, clamping at both table ends.
//
//   port           dir  width  meaning
//   start          in   1      take adc_sample when busy is low
//   busy           out  1      high during reset only
//   adc_sample     in   12     raw ADC reading
//   done           out  1      result strobe, one cycle per item
//   temp_tenths    out  12     temperature, 0.1 degC
//   clamp_status   out  2      interpolated / cold clamp / hot clamp
//
// Fully pipelined: one item may enter every cycle, and done rises once the
// item has passed 4 search/lookup/multiply stages, 6 divider stages for the
// 6 quotient bits and 1 output register.
// Reset clears the valid bits of all stages; items in flight are dropped.
// Nothing stalls: results leave on their own strobe.
// ----------------------------------------------------------------------------
module ntc_adc_to_temperature_unit import ntc_pkg::*; #(
  parameter int TABLE_ENTRIES = 43
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [ADC_W-1:0]  adc_sample,
  output logic              done,
  output logic [TEMP_W-1:0] temp_tenths,
  output logic [STAT_W-1:0] clamp_status
);

  localparam int USED = (TABLE_ENTRIES < 2) ? 2 :
                        ((TABLE_ENTRIES > ROM_SIZE) ? ROM_SIZE : TABLE_ENTRIES);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(USED - 1);
  localparam int LATENCY = 5 + Q_W;

  logic take;
  assign busy = rst;
  assign take = start & ~busy;

  // Stage 1: compare against every breakpoint
  logic                s1_vld;
  logic [ADC_W-1:0]    s1_x;
  logic [ROM_SIZE-1:0] s1_lt;
  logic [STAT_W-1:0]   s1_stat;
  logic [ROM_SIZE-1:0] lt_next;
  logic [STAT_W-1:0]   stat_next;

  always_comb begin
    for (int i = 0; i < ROM_SIZE; i++) begin
      lt_next[i] = BP_ADC[i] < adc_sample;
    end
    if (adc_sample <= adc_at(LAST)) begin
      stat_next = ST_HOT;
    end else if (adc_sample >= BP_ADC[0]) begin
      stat_next = ST_COLD;
    end else begin
      stat_next = ST_INTERP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= take;
    end
    s1_x    <= adc_sample;
    s1_lt   <= lt_next;
    s1_stat <= stat_next;
  end

  // Stage 2: first breakpoint below the sample
  logic              s2_vld;
  logic [ADC_W-1:0]  s2_x;
  logic [IDX_W-1:0]  s2_idx;
  logic [STAT_W-1:0] s2_stat;
  logic [IDX_W-1:0]  idx_next;

  always_comb begin
    idx_next = IDX_W'(1);
    for (int i = ROM_SIZE - 1; i >= 1; i--) begin
      if (i < USED && s1_lt[i]) idx_next = IDX_W'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else begin
      s2_vld <= s1_vld;
    end
    s2_x    <= s1_x;
    s2_idx  <= idx_next;
    s2_stat <= s1_stat;
  end

  // Stage 3: fetch the segment ends
  logic              s3_vld;
  logic [SPAN_W-1:0] s3_dx;
  logic [SPAN_W-1:0] s3_span;
  logic [DY_W-1:0]   s3_dy;
  div_tag_t          s3_tag;
  logic [ADC_W-1:0]  x0, x1, dx_full, span_full;
  logic [TEMP_W-1:0] y0, y1, dy_full;

  always_comb begin
    x0        = adc_at(s2_idx - IDX_W'(1));
    x1        = adc_at(s2_idx);
    y0        = temp_at(s2_idx - IDX_W'(1));
    y1        = temp_at(s2_idx);
    dx_full   = x0 - s2_x;
    span_full = x0 - x1;
    dy_full   = y1 - y0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else begin
      s3_vld <= s2_vld;
    end
    s3_tag.status <= s2_stat;
    case (s2_stat)
      ST_INTERP: begin
        s3_tag.base <= y0;
        s3_dx       <= dx_full[SPAN_W-1:0];
        s3_span     <= span_full[SPAN_W-1:0];
        s3_dy       <= dy_full[DY_W-1:0];
      end
      ST_COLD: begin
        s3_tag.base <= BP_TEMP[0];
        s3_dx       <= '0;
        s3_span     <= SPAN_W'(1);
        s3_dy       <= '0;
      end
      default: begin
        s3_tag.base <= temp_at(LAST);
        s3_dx       <= '0;
        s3_span     <= SPAN_W'(1);
        s3_dy       <= '0;
      end
    endcase
  end

  // Stage 4: numerator product
  logic              s4_vld;
  logic [NUM_W-1:0]  s4_num;
  logic [SPAN_W-1:0] s4_span;
  div_tag_t          s4_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_vld <= 1'b0;
    end else begin
      s4_vld <= s3_vld;
    end
    s4_num  <= NUM_W'(s3_dx) * NUM_W'(s3_dy);
    s4_span <= s3_span;
    s4_tag  <= s3_tag;
  end

  logic           dv_vld;
  logic [Q_W-1:0] dv_quot;
  div_tag_t       dv_tag;

  ntc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s4_vld),
    .num       (s4_num),
    .span      (s4_span),
    .in_tag    (s4_tag),
    .out_valid (dv_vld),
    .quot      (dv_quot),
    .out_tag   (dv_tag)
  );

  // Output register: add the truncated step to the segment base
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv_vld;
    end
    temp_tenths  <= dv_tag.base + {{(TEMP_W-Q_W){1'b0}}, dv_quot};
    clamp_status <= dv_tag.status;
  end

  a_latency : assert property (@(posedge clk) disable iff (rst)
    take |-> ##LATENCY done)
    else $error("accepted item did not produce a result on time");

  a_range : assert property (@(posedge clk) disable iff (rst)
    done |-> (temp_tenths >= BP_TEMP[0] && temp_tenths <= temp_at(LAST)))
    else $error("temperature outside the table range");

  a_cold : assert property (@(posedge clk) disable iff (rst)
    done && clamp_status == ST_COLD |-> temp_tenths == BP_TEMP[0])
    else $error("cold clamp with wrong temperature");

  a_hot : assert property (@(posedge clk) disable iff (rst)
    done && clamp_status == ST_HOT |-> temp_tenths == temp_at(LAST))
    else $error("hot clamp with wrong temperature");

  a_status : assert property (@(posedge clk) disable iff (rst)
    done |-> (clamp_status == ST_INTERP || clamp_status == ST_COLD ||
              clamp_status == ST_HOT))
    else $error("unknown clamp status code");

endmodule
